// ===== sv/bphc_pkg.sv =====
// Shared types and constants for the button press/hold classifier.
package bphc_pkg;

    localparam int unsigned NUM_BUTTONS = 6;
    localparam int unsigned TICK_W      = 32;
    localparam int unsigned PIN_W       = 8;
    localparam int unsigned CFG_IDX_W   = 3;

    typedef enum logic [1:0] {
        PH_OFF      = 2'd0,
        PH_PRESSED  = 2'd1,
        PH_HELD     = 2'd2,
        PH_RELEASED = 2'd3
    } t_phase;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HOLD_TICKS    = 3'd0,
        REG_RELEASE_TICKS = 3'd1,
        REG_MASK_UP       = 3'd2,
        REG_MASK_DOWN     = 3'd3,
        REG_MASK_LEFT     = 3'd4,
        REG_MASK_RIGHT    = 3'd5,
        REG_MASK_OK       = 3'd6,
        REG_MASK_BACK     = 3'd7
    } t_reg_idx;

    // One sample as seen by every lane, plus the accept strobe.
    typedef struct packed {
        logic              accept;
        logic [PIN_W-1:0]  pins;
        logic [TICK_W-1:0] tick;
    } t_sample;

    typedef struct packed {
        logic [TICK_W-1:0] hold_ticks;
        logic [TICK_W-1:0] release_ticks;
    } t_thresholds;

    typedef logic [NUM_BUTTONS-1:0][PIN_W-1:0] t_mask_vec;
    typedef t_phase [NUM_BUTTONS-1:0]          t_phase_vec;

    localparam t_mask_vec MASK_RESET = {8'h20, 8'h10, 8'h08, 8'h04, 8'h02, 8'h01};

endpackage

// ===== sv/bphc_lane.sv =====
// One button lane: press test, four-phase machine and timestamp.
module bphc_lane
    import bphc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_sample              i_sample,
    input  t_thresholds          i_thr,
    input  logic [PIN_W-1:0]     i_mask,
    output t_phase               o_next_phase
);

    t_phase              r_phase;
    t_phase              n_phase;
    logic [TICK_W-1:0]   r_stamp;
    logic                pressed;
    logic                stamp_load;
    logic [TICK_W-1:0]   hold_limit;
    logic [TICK_W-1:0]   release_limit;
    logic                hold_due;
    logic                release_due;

    assign pressed       = (i_sample.pins & i_mask) == '0;
    // Sums wrap at the tick width before the unsigned compare.
    assign hold_limit    = r_stamp + i_thr.hold_ticks;
    assign release_limit = r_stamp + i_thr.release_ticks;
    assign hold_due      = i_sample.tick > hold_limit;
    assign release_due   = i_sample.tick > release_limit;

    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_OFF: begin
                n_phase = pressed ? PH_PRESSED : PH_OFF;
            end
            PH_PRESSED: begin
                if (!pressed) begin
                    n_phase = PH_RELEASED;
                end else if (hold_due) begin
                    n_phase = PH_HELD;
                end
            end
            PH_HELD: begin
                n_phase = pressed ? PH_HELD : PH_RELEASED;
            end
            PH_RELEASED: begin
                if (pressed) begin
                    n_phase = PH_PRESSED;
                end else if (release_due) begin
                    n_phase = PH_OFF;
                end
            end
            default: begin
                n_phase = PH_OFF;
            end
        endcase
    end

    // Stamp refresh: in off and held, and on re-press from released.
    always_comb begin
        case (r_phase)
            PH_OFF:      stamp_load = 1'b1;
            PH_HELD:     stamp_load = 1'b1;
            PH_RELEASED: stamp_load = pressed;
            default:     stamp_load = 1'b0;
        endcase
    end

    assign o_next_phase = n_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_OFF;
        end else if (i_sample.accept) begin
            r_phase <= n_phase;
        end
    end

    // Off always reloads the stamp before it is read, so no reset is needed.
    always_ff @(posedge i_clk) begin
        if (i_sample.accept && stamp_load) begin
            r_stamp <= i_sample.tick;
        end
    end

endmodule

// ===== sv/bphc_merge.sv =====
// Result stage: gathers the six lane phases into one registered item.
module bphc_merge
    import bphc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_phase_vec  i_phases,
    input  logic        i_ready,
    output logic        o_valid,
    output logic        o_can_load,
    output t_phase_vec  o_phases
);

    logic       r_valid;
    t_phase_vec r_phases;

    // Take a new item when empty or when the held one leaves this cycle.
    assign o_can_load = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_phases <= i_phases;
        end
    end

    assign o_valid  = r_valid;
    assign o_phases = r_phases;

endmodule

// ===== sv/button_press_hold_classifier.sv =====
// Button press/hold classifier top level: config registers, six lanes, result stage.
//
// Each accepted item is one sample of an active-low pin byte and a tick count;
// every sample yields one result with the off/pressed/held/released phase of
// the up, down, left, right, ok and back buttons. All six buttons are updated side
// by side, one 32-bit add and compare per threshold per lane, so a sample is
// accepted every clock while input ready is high, and its result is registered
// in the result stage. Input ready stays high while the result register is empty or
// being drained, so a stalled output holds only one result. A button is pressed when
// every pin selected by its mask reads zero; a zero mask reads as always pressed.
// Threshold sums wrap modulo 2^32. The user must write registers through the plain
// write port while no sample is in flight; the block does not enforce this.
module button_press_hold_classifier
    import bphc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [TICK_W-1:0]    i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [PIN_W-1:0]     i_pin_levels,
    input  logic [TICK_W-1:0]    i_tick_now,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [1:0]           o_up_state,
    output logic [1:0]           o_down_state,
    output logic [1:0]           o_left_state,
    output logic [1:0]           o_right_state,
    output logic [1:0]           o_ok_state,
    output logic [1:0]           o_back_state
);

    t_thresholds r_thr;
    t_mask_vec   r_mask;
    t_sample     sample;
    t_phase_vec  lane_phase;
    t_phase_vec  out_phase;
    logic        can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= '0;
            r_mask <= MASK_RESET;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_HOLD_TICKS:    r_thr.hold_ticks    <= i_cfg_data;
                REG_RELEASE_TICKS: r_thr.release_ticks <= i_cfg_data;
                REG_MASK_UP:       r_mask[0] <= i_cfg_data[PIN_W-1:0];
                REG_MASK_DOWN:     r_mask[1] <= i_cfg_data[PIN_W-1:0];
                REG_MASK_LEFT:     r_mask[2] <= i_cfg_data[PIN_W-1:0];
                REG_MASK_RIGHT:    r_mask[3] <= i_cfg_data[PIN_W-1:0];
                REG_MASK_OK:       r_mask[4] <= i_cfg_data[PIN_W-1:0];
                REG_MASK_BACK:     r_mask[5] <= i_cfg_data[PIN_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_ready       = can_load;
    assign sample.accept = i_valid && can_load;
    assign sample.pins   = i_pin_levels;
    assign sample.tick   = i_tick_now;

    for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
        bphc_lane u_lane (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_sample     (sample),
            .i_thr        (r_thr),
            .i_mask       (r_mask[g]),
            .o_next_phase (lane_phase[g])
        );
    end

    bphc_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (sample.accept),
        .i_phases   (lane_phase),
        .i_ready    (i_ready),
        .o_valid    (o_valid),
        .o_can_load (can_load),
        .o_phases   (out_phase)
    );

    assign o_up_state    = out_phase[0];
    assign o_down_state  = out_phase[1];
    assign o_left_state  = out_phase[2];
    assign o_right_state = out_phase[3];
    assign o_ok_state    = out_phase[4];
    assign o_back_state  = out_phase[5];

endmodule
